// File: src/rsas_pkg.sv
`default_nettype none

package rsas_pkg;

  // Array geometry
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  // Signed loop bounds: two bits wider than an index so that -1 and CAPACITY both fit
  localparam int BND_W    = IDX_W + 2;
  localparam int DATA_W   = 32;

  // Action codes
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_EMPTY  = 2'd2;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_word_t;

endpackage

`default_nettype wire

// File: src/rotated_sorted_array_search_core.sv
`default_nettype none

// Channel  Direction  Handshake               Word
// in       input      in_valid_i / in_stall_o   in_word_i  (action, value)
// out      output     out_valid_o / out_stall_i out_word_o (found, position)
//
// Append, empty and unused actions complete without leaving the idle state.
// A search reads the first and last elements, halves toward the pivot, then binary-searches
// the run that can hold the target and registers the answer; the single read port
// of the element store sets the pace, one read per step.
// Reset clears the element count and all control state; the store itself is not cleared.
// A finished result waits in the output register; a stalled output holds the block
// only when the next search result is ready to replace it.
module rotated_sorted_array_search_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rsas_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rsas_pkg::out_word_t      out_word_o
);
  import rsas_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_RD_FIRST = 11'b00000000010,
    S_RD_LAST  = 11'b00000000100,
    S_GOT_LAST = 11'b00000001000,
    S_PIV_RD   = 11'b00000010000,
    S_PIV_DIF  = 11'b00000100000,
    S_PIV_UPD  = 11'b00001000000,
    S_SPLIT    = 11'b00010000000,
    S_BS_RD    = 11'b00100000000,
    S_BS_CMP   = 11'b01000000000,
    S_RESP     = 11'b10000000000
  } state_e;

  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [DATA_W-1:0]  target_q, target_d;
  logic signed [DATA_W-1:0]  first_q, first_d;
  logic signed [DATA_W-1:0]  last_q, last_d;
  logic signed [DATA_W-1:0]  lo_val_q, lo_val_d;
  logic signed [DATA_W-1:0]  hi_val_q, hi_val_d;
  logic signed [DATA_W-1:0]  m_q, m_d;
  logic signed [DATA_W:0]    dlo_q, dlo_d;
  logic signed [DATA_W:0]    dhi_q, dhi_d;
  logic signed [BND_W-1:0]   lo_q, lo_d;
  logic signed [BND_W-1:0]   hi_q, hi_d;
  logic [IDX_W-1:0]          mid_q, mid_d;
  logic                      found_q, found_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic                      out_valid_q, out_valid_d;
  out_word_t                 out_word_q, out_word_d;

  logic                      in_acc;
  logic                      ram_we;
  logic [IDX_W-1:0]          ram_addr;
  logic [DATA_W-1:0]         ram_rdata;
  logic signed [DATA_W-1:0]  rd_val;
  logic [CNT_W-1:0]          n_m1;
  logic [DATA_W:0]           mag_lo, mag_hi;
  logic signed [BND_W-1:0]   mid_ext;
  logic signed [BND_W-1:0]   lo_nx, hi_nx;
  logic signed [BND_W:0]     bnd_sum;
  logic [IDX_W-1:0]          piv_idx;
  logic signed [DATA_W-1:0]  piv_val;
  logic                      ascending;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign rd_val      = ram_rdata;
  assign n_m1        = count_q - CNT_W'(1);
  assign mid_ext     = BND_W'({1'b0, mid_q});
  assign mag_lo      = dlo_q[DATA_W] ? (DATA_W+1)'(-dlo_q) : (DATA_W+1)'(dlo_q);
  assign mag_hi      = dhi_q[DATA_W] ? (DATA_W+1)'(-dhi_q) : (DATA_W+1)'(dhi_q);
  assign ascending   = (first_q < last_q);

  // Pivot: last index on an unrotated array, else where the halving stopped
  always_comb begin
    if (ascending) begin
      piv_idx = n_m1[IDX_W-1:0];
      piv_val = last_q;
    end else begin
      piv_idx = mid_q;
      piv_val = (lo_q == mid_ext) ? lo_val_q : hi_val_q;
    end
  end

  rsas_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_word_i.value),
    .rdata_o (ram_rdata)
  );

  // Control sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    target_d    = target_q;
    first_d     = first_q;
    last_d      = last_q;
    lo_val_d    = lo_val_q;
    hi_val_d    = hi_val_q;
    m_d         = m_q;
    dlo_d       = dlo_q;
    dhi_d       = dhi_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    found_d     = found_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    ram_we      = 1'b0;
    ram_addr    = count_q[IDX_W-1:0];
    lo_nx       = lo_q;
    hi_nx       = hi_q;
    bnd_sum     = '0;

    // Output register drains independently
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_word_i.action)
            ACT_APPEND: begin
              if (count_q < CNT_W'(CAPACITY)) begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_EMPTY: begin
              count_d = '0;
            end
            ACT_SEARCH: begin
              target_d = in_word_i.value;
              found_d  = 1'b0;
              pos_d    = '0;
              state_d  = (count_q == '0) ? S_RESP : S_RD_FIRST;
            end
            default: ;
          endcase
        end
      end
      S_RD_FIRST: begin
        ram_addr = '0;
        state_d  = S_RD_LAST;
      end
      S_RD_LAST: begin
        ram_addr = n_m1[IDX_W-1:0];
        first_d  = rd_val;
        state_d  = S_GOT_LAST;
      end
      S_GOT_LAST: begin
        last_d   = rd_val;
        lo_val_d = first_q;
        hi_val_d = rd_val;
        lo_d     = '0;
        hi_d     = BND_W'(n_m1);
        mid_d    = n_m1[IDX_W:1];
        state_d  = S_PIV_RD;
      end
      // Halving loop: one element read per step, end values kept in registers
      S_PIV_RD: begin
        ram_addr = mid_q;
        if (lo_q != mid_ext && hi_q != mid_ext) begin
          state_d = S_PIV_DIF;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_PIV_DIF: begin
        m_d     = rd_val;
        dlo_d   = (DATA_W+1)'(lo_val_q) - (DATA_W+1)'(rd_val);
        dhi_d   = (DATA_W+1)'(hi_val_q) - (DATA_W+1)'(rd_val);
        state_d = S_PIV_UPD;
      end
      S_PIV_UPD: begin
        if (mag_lo > mag_hi) begin
          hi_nx    = mid_ext;
          hi_val_d = m_q;
        end else begin
          lo_nx    = mid_ext;
          lo_val_d = m_q;
        end
        lo_d    = lo_nx;
        hi_d    = hi_nx;
        bnd_sum = (BND_W+1)'(lo_nx) + (BND_W+1)'(hi_nx);
        mid_d   = bnd_sum[IDX_W:1];
        state_d = S_PIV_RD;
      end
      // Pick the run that can hold the target
      S_SPLIT: begin
        if (target_q == piv_val) begin
          found_d = 1'b1;
          pos_d   = piv_idx;
          state_d = S_RESP;
        end else if (target_q > first_q) begin
          lo_d    = '0;
          hi_d    = BND_W'({1'b0, piv_idx}) - BND_W'(1);
          state_d = S_BS_RD;
        end else if (target_q < first_q) begin
          lo_d    = BND_W'({1'b0, piv_idx}) + BND_W'(1);
          hi_d    = BND_W'(n_m1);
          state_d = S_BS_RD;
        end else begin
          found_d = 1'b1;
          pos_d   = '0;
          state_d = S_RESP;
        end
      end
      // Binary search
      S_BS_RD: begin
        bnd_sum  = (BND_W+1)'(lo_q) + (BND_W+1)'(hi_q);
        ram_addr = bnd_sum[IDX_W:1];
        mid_d    = bnd_sum[IDX_W:1];
        state_d  = (lo_q <= hi_q) ? S_BS_CMP : S_RESP;
      end
      S_BS_CMP: begin
        if (rd_val < target_q) begin
          lo_d    = mid_ext + BND_W'(1);
          state_d = S_BS_RD;
        end else if (rd_val > target_q) begin
          hi_d    = mid_ext - BND_W'(1);
          state_d = S_BS_RD;
        end else begin
          found_d = 1'b1;
          pos_d   = mid_q;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_word_d.found    = found_q;
          out_word_d.position = found_q ? pos_q : '0;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    target_q   <= target_d;
    first_q    <= first_d;
    last_q     <= last_d;
    lo_val_q   <= lo_val_d;
    hi_val_q   <= hi_val_d;
    m_q        <= m_d;
    dlo_q      <= dlo_d;
    dhi_q      <= dhi_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    out_word_q <= out_word_d;
  end

endmodule

`default_nettype wire

// File: src/rsas_ram.sv
`default_nettype none

// Single-port element store, registered read data
module rsas_ram (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [rsas_pkg::IDX_W-1:0]  addr_i,
  input  wire logic [rsas_pkg::DATA_W-1:0] wdata_i,
  output logic      [rsas_pkg::DATA_W-1:0] rdata_o
);
  import rsas_pkg::*;

  logic [DATA_W-1:0] mem_q [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: src/rsas_checker.sv
`default_nettype none

module rsas_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire rsas_pkg::in_word_t  in_word_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire rsas_pkg::out_word_t out_word_o
);
  import rsas_pkg::*;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result word changed under stall");

  // A miss never carries a position
  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.found) |-> (out_word_o.position == '0))
    else $error("miss with nonzero position");

  // A search keeps the input side busy until its answer is formed
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.action == ACT_SEARCH) |=> in_stall_o)
    else $error("search accepted without going busy");

  // Loads, empties and unused codes never leave the input side busy
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.action != ACT_SEARCH) |=> !in_stall_o)
    else $error("non-search word left the block busy");

  // A result only appears out of a busy search
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a search in flight");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rsas_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam int ITEMS_GOAL = 1550;
  localparam int STALL_HOLD = 400;
  localparam int HOLD_AFTER = 30;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int REPORT_MAX = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  in_word_t in_word = '0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // Words waiting to be sent and answers waiting to come back
  in_word_t word_q[$];
  out_word_t answer_q[$];

  // Shadow copy of the array held by the block
  int arr_mem[CAPACITY];
  int arr_len = 0;

  int send_idle_pct = 17;
  int recv_idle_pct = 59;
  int send_calm = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  int items_made = 0;
  int words_sent = 0;
  int searches_sent = 0;
  int hits_due = 0;
  int longest_arr = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic drv_valid;
  in_word_t drv_word;
  out_word_t new_answer;
  out_word_t due_answer;

  rotated_sorted_array_search_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint elem_at(int i);
    return longint'(arr_mem[i]);
  endfunction

  function automatic longint spread(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Pivot walk, then binary search of the run that can hold the target
  function automatic out_word_t search_answer(int target);
    int lo, hi, mid, pivot;
    longint t, m;
    out_word_t ans;
    ans = '0;
    t = target;
    if (arr_len == 0) return ans;
    lo = 0;
    hi = arr_len - 1;
    mid = hi / 2;
    while (lo != mid && hi != mid) begin
      m = elem_at(mid);
      if (spread(elem_at(lo), m) > spread(elem_at(hi), m)) hi = mid;
      else lo = mid;
      mid = (lo + hi) / 2;
    end
    // not rotated: the largest element sits at the end
    pivot = (elem_at(0) < elem_at(arr_len - 1)) ? arr_len - 1 : mid;
    if (t == elem_at(pivot)) begin
      ans.found = 1'b1;
      ans.position = IDX_W'(pivot);
      return ans;
    end
    if (t == elem_at(0)) begin
      ans.found = 1'b1;
      return ans;
    end
    if (t > elem_at(0)) begin
      lo = 0;
      hi = pivot - 1;
    end else begin
      lo = pivot + 1;
      hi = arr_len - 1;
    end
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      m = elem_at(mid);
      if (m < t) lo = mid + 1;
      else if (m > t) hi = mid - 1;
      else begin
        ans.found = 1'b1;
        ans.position = IDX_W'(mid);
        return ans;
      end
    end
    return ans;
  endfunction

  task automatic queue_word(logic [1:0] act, int val);
    in_word_t w;
    w.action = act;
    w.value = val;
    word_q.push_back(w);
    if (act != ACT_UNUSED) items_made++;
  endtask

  // One array: restart (always when clean), loads, then searches. A clean array is a rotated
  // ascending run of distinct values; otherwise contents are random and
  // noise words are mixed in.
  task automatic queue_sequence(int n, bit clean, int extra);
    longint offs[$];
    int vals[$];
    longint gmax, base, acc;
    int rot, top, target, idx;
    if (clean && n > 0) begin
      case ($urandom_range(2))
        0: gmax = 3;
        1: gmax = 1000;
        default: gmax = (n > 1) ? 64'd4294967295 / (n - 1) : 64'd4294967295;
      endcase
      acc = 0;
      for (int k = 0; k < n; k++) begin
        offs.push_back(acc);
        acc += longint'($urandom_range(32'(gmax), 1));
      end
      // pin the run to the bottom, the top, or anywhere in range
      case ($urandom_range(2))
        0: base = WORD_MIN;
        1: base = WORD_MAX - offs[n-1];
        default: base = WORD_MIN + longint'($urandom_range(32'(64'd4294967295 - offs[n-1])));
      endcase
      rot = $urandom_range(n - 1);
      for (int k = 0; k < n; k++) vals.push_back(int'(base + offs[(rot + k) % n]));
    end else begin
      for (int k = 0; k < n; k++)
        vals.push_back((k > 0 && $urandom_range(3) == 0) ?
                       vals[$urandom_range(k - 1)] : int'($urandom));
    end

    if (clean || $urandom_range(1) == 1) queue_word(ACT_EMPTY, int'($urandom));
    foreach (vals[k]) begin
      queue_word(ACT_APPEND, vals[k]);
      if (!clean && $urandom_range(7) == 0) begin
        case ($urandom_range(2))
          0: queue_word(ACT_UNUSED, int'($urandom));
          1: queue_word(ACT_SEARCH, int'($urandom));
          default: queue_word(ACT_EMPTY, int'($urandom));
        endcase
      end
    end
    // loads past a full array are dropped
    repeat (extra) queue_word(ACT_APPEND, int'($urandom));

    top = (n > 0) ? vals[0] : 0;
    foreach (vals[k]) if (vals[k] > top) top = vals[k];
    repeat ($urandom_range(6, 1)) begin
      idx = (n > 0) ? $urandom_range(n - 1) : 0;
      if (n == 0) target = int'($urandom);
      else begin
        case ($urandom_range(6))
          0, 1: target = vals[idx];
          2: target = vals[0];
          3: target = top;
          4: target = vals[idx] + (($urandom_range(1) == 1) ? 1 : -1);
          5: target = ($urandom_range(1) == 1) ? int'(WORD_MIN) : int'(WORD_MAX);
          default: target = int'($urandom);
        endcase
      end
      queue_word(ACT_SEARCH, target);
    end
  endtask

  // Mostly small arrays, a few hundred elements now and then
  task automatic queue_random_sequence();
    int pick, n;
    pick = $urandom_range(99);
    if (pick < 5) n = 0;
    else if (pick < 70) n = $urandom_range(16, 1);
    else if (pick < 95) n = $urandom_range(120, 17);
    else n = $urandom_range(400, 121);
    queue_sequence(n, $urandom_range(99) < 80, 0);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_valid || answer_q.size() != 0);
  endtask

  // Driver: offers words from word_q and updates the shadow array on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else begin
      drv_valid = in_valid;
      drv_word = in_word;
      if (in_valid && !in_stall) begin
        words_sent++;
        case (in_word.action)
          ACT_APPEND: begin
            if (arr_len < CAPACITY) begin
              arr_mem[arr_len] = in_word.value;
              arr_len++;
              if (arr_len > longest_arr) longest_arr = arr_len;
            end
          end
          ACT_EMPTY: arr_len = 0;
          ACT_SEARCH: begin
            new_answer = search_answer(in_word.value);
            answer_q.push_back(new_answer);
            searches_sent++;
            if (new_answer.found) hits_due++;
          end
          default: ;
        endcase
        drv_valid = 1'b0;
      end
      if (send_calm > 0) send_calm--;
      else if ($urandom_range(199) == 0) send_calm = 60;
      if (!drv_valid && word_q.size() != 0 &&
          (send_calm > 0 || $urandom_range(99) >= send_idle_pct)) begin
        drv_word = word_q.pop_front();
        drv_valid = 1'b1;
      end
      in_valid <= drv_valid;
      in_word <= drv_word;
    end
  end

  // Monitor: checks each accepted result against the oldest answer due
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR: result with no search outstanding: found=%0b position=%0d",
                     out_word.found, out_word.position);
        end else begin
          due_answer = answer_q.pop_front();
          if (out_word.found !== due_answer.found ||
              out_word.position !== due_answer.position) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display({"ERROR: result %0d expected found=%0b position=%0d, ",
                        "got found=%0b position=%0d"},
                       results_seen, due_answer.found, due_answer.position,
                       out_word.found, out_word.position);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (hold_left == 0 && !hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = STALL_HOLD;
        hold_done = 1'b1;
      end
      if (recv_calm > 0) recv_calm--;
      else if ($urandom_range(199) == 0) recv_calm = 60;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (recv_calm == 0) && ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty array, unused code, extremes, first and largest element,
    // absent targets, an unrotated run and a single element with empty run
    queue_word(ACT_SEARCH, 0);
    queue_word(ACT_UNUSED, -1);
    queue_word(ACT_APPEND, 5);
    queue_word(ACT_APPEND, int'(WORD_MAX));
    queue_word(ACT_APPEND, int'(WORD_MIN));
    queue_word(ACT_APPEND, -7);
    queue_word(ACT_APPEND, 0);
    queue_word(ACT_SEARCH, 5);
    queue_word(ACT_SEARCH, int'(WORD_MAX));
    queue_word(ACT_SEARCH, int'(WORD_MIN));
    queue_word(ACT_SEARCH, 0);
    queue_word(ACT_SEARCH, 3);
    queue_word(ACT_SEARCH, -8);
    queue_word(ACT_EMPTY, -1);
    queue_word(ACT_SEARCH, 1);
    queue_word(ACT_APPEND, 10);
    queue_word(ACT_APPEND, 20);
    queue_word(ACT_APPEND, 30);
    queue_word(ACT_SEARCH, 30);
    queue_word(ACT_SEARCH, 10);
    queue_word(ACT_SEARCH, 25);
    queue_word(ACT_EMPTY, 0);
    queue_word(ACT_APPEND, 9);
    queue_word(ACT_SEARCH, 12);
    queue_word(ACT_SEARCH, 9);

    while (items_made < 260) queue_random_sequence();
    wait_drained();

    send_idle_pct = 59;
    recv_idle_pct = 17;
    while (items_made < 520) queue_random_sequence();
    wait_drained();

    // No idling; one full array with loads past capacity
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_sequence(CAPACITY, 1'b1, 3);
    while (items_made < ITEMS_GOAL) queue_random_sequence();
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      mismatches += answer_q.size();
      $display("ERROR: %0d searches never answered", answer_q.size());
    end

    $display("Sent %0d words: %0d searches (%0d hits), arrays up to %0d elements",
             words_sent, searches_sent, hits_due, longest_arr);
    $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
